/* rtl/swtone_pkg.sv */
// Package for the square-wave tone register device.
// Request and response payload types, bus function codes and register indexes.
// No dependencies.
package swtone_pkg;

   localparam logic [1:0] FUNC_IDLE  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;
   localparam logic [1:0] FUNC_TICK  = 2'd3;

   localparam logic [4:0] REG_CTRL     = 5'd0;
   localparam logic [4:0] REG_PERIOD_L = 5'd1;
   localparam logic [4:0] REG_PERIOD_H = 5'd2;

   localparam int PERIOD_W  = 11;
   localparam int DIV_STEPS = PERIOD_W + 1;

   typedef struct packed {
      logic [1:0] func;
      logic [4:0] reg_addr;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        drives_bus;
      logic        tone_level;
      logic [31:0] edge_count;
      logic [31:0] high_count;
   } rsp_type;

endpackage

/* rtl/square_wave_tone_register_device_core.sv */
// Square-wave tone generator, byte-wide register file in a synchronous RAM; uses swtone_pkg.
// Sequence: idle and write requests go straight to ST_OUT, a read passes through ST_READ,
// a sample tick through ST_T1 to ST_T3 (three RAM reads), a 12-step restoring remainder in
// ST_DIV, and ST_UPD. The next request is taken once the result is parked in the response
// register. Reset clears all entry valid bits (unwritten registers read as zero), the phase,
// the tone level and both tallies, with no sweep.
module square_wave_tone_register_device_core #(
   parameter int NUM_REGS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  swtone_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output swtone_pkg::rsp_type rsp_payload
);

   localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int PW = swtone_pkg::PERIOD_W;
   localparam int CW = $clog2(swtone_pkg::DIV_STEPS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_T1   = 3'd2;
   localparam logic [2:0] ST_T2   = 3'd3;
   localparam logic [2:0] ST_T3   = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_UPD  = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   logic [7:0] mem [NUM_REGS];
   logic [7:0] mem_rdata_ff;
   logic       mem_rvalid_ff;
   logic       mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;

   logic [NUM_REGS-1:0] valid_ff, valid_in;
   logic [2:0]  state_ff, state_in;
   logic [PW-1:0] phase_ff, phase_in;
   logic        level_ff, level_in;
   logic [31:0] edge_ff, edge_in;
   logic [31:0] high_ff, high_in;
   logic        en_ff, en_in;
   logic [3:0]  vol_ff, vol_in;
   logic [7:0]  plo_ff, plo_in;
   logic [PW-1:0] period_ff, period_in;
   logic        run_ff, run_in;
   logic [PW:0] num_ff, num_in;
   logic [PW:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]  byte_ff, byte_in;
   logic        drive_ff, drive_in;
   logic        in_range_ff, in_range_in;
   logic        rsp_valid_ff, rsp_valid_in;
   swtone_pkg::rsp_type rsp_ff, rsp_in;

   logic          req_ok;
   logic          addr_ok;
   logic [AW-1:0] addr_idx;
   logic [7:0]    rd_byte;
   logic [PW-1:0] period_new;
   logic [PW:0]   rem_sh;
   logic          new_level;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_ok      = req_valid && (state_ff == ST_IDLE);
   assign addr_ok     = {1'b0, req_payload.reg_addr} < 6'(NUM_REGS);
   assign addr_idx    = addr_ok ? req_payload.reg_addr[AW-1:0] : '0;
   assign rd_byte     = mem_rvalid_ff ? mem_rdata_ff : 8'd0;
   assign period_new  = {rd_byte[2:0], plo_ff};
   assign rem_sh      = {rem_ff[PW-1:0], num_ff[PW]};
   assign new_level   = run_ff && (rem_ff[PW-1:0] < {1'b0, period_ff[PW-1:1]})
                        && (vol_ff != 4'd0);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      mem_we      = 1'b0;
      mem_waddr   = addr_idx;
      mem_raddr   = '0;
      valid_in    = valid_ff;
      state_in    = state_ff;
      phase_in    = phase_ff;
      level_in    = level_ff;
      edge_in     = edge_ff;
      high_in     = high_ff;
      en_in       = en_ff;
      vol_in      = vol_ff;
      plo_in      = plo_ff;
      period_in   = period_ff;
      run_in      = run_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      byte_in     = byte_ff;
      drive_in    = drive_ff;
      in_range_in = in_range_ff;
      rsp_in      = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_ok) begin
               byte_in     = 8'd0;
               drive_in    = 1'b0;
               in_range_in = addr_ok;
               mem_raddr   = addr_idx;
               case (req_payload.func)
                  swtone_pkg::FUNC_WRITE: begin
                     mem_we = addr_ok;
                     if (addr_ok) begin
                        valid_in[addr_idx] = 1'b1;
                     end
                     state_in = ST_OUT;
                  end
                  swtone_pkg::FUNC_READ: begin
                     state_in = ST_READ;
                  end
                  swtone_pkg::FUNC_TICK: begin
                     mem_raddr = AW'(swtone_pkg::REG_CTRL);
                     state_in  = ST_T1;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_READ: begin
            byte_in  = in_range_ff ? rd_byte : 8'd0;
            drive_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_T1: begin
            en_in     = rd_byte[0];
            vol_in    = rd_byte[7:4];
            mem_raddr = AW'(swtone_pkg::REG_PERIOD_L);
            state_in  = ST_T2;
         end
         ST_T2: begin
            plo_in    = rd_byte;
            mem_raddr = AW'(swtone_pkg::REG_PERIOD_H);
            state_in  = ST_T3;
         end
         ST_T3: begin
            period_in = period_new;
            run_in    = en_ff && (period_new > PW'(1));
            num_in    = {1'b0, phase_ff} + (PW+1)'(1);
            rem_in    = '0;
            cnt_in    = CW'(swtone_pkg::DIV_STEPS);
            state_in  = (en_ff && (period_new > PW'(1))) ? ST_DIV : ST_UPD;
         end
         ST_DIV: begin
            num_in = {num_ff[PW-1:0], 1'b0};
            rem_in = (rem_sh >= {1'b0, period_ff}) ? (rem_sh - {1'b0, period_ff}) : rem_sh;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            phase_in = run_ff ? rem_ff[PW-1:0] : '0;
            edge_in  = edge_ff + {31'd0, (new_level != level_ff)};
            high_in  = high_ff + {31'd0, new_level};
            level_in = new_level;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.read_data  = byte_ff;
               rsp_in.drives_bus = drive_ff;
               rsp_in.tone_level = level_ff;
               rsp_in.edge_count = edge_ff;
               rsp_in.high_count = high_ff;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // register file RAM, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_payload.write_data;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         mem_rvalid_ff <= 1'b0;
         phase_ff      <= '0;
         level_ff      <= 1'b0;
         edge_ff       <= '0;
         high_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         mem_rvalid_ff <= valid_ff[mem_raddr];
         phase_ff      <= phase_in;
         level_ff      <= level_in;
         edge_ff       <= edge_in;
         high_ff       <= high_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      en_ff       <= en_in;
      vol_ff      <= vol_in;
      plo_ff      <= plo_in;
      period_ff   <= period_in;
      run_ff      <= run_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      byte_ff     <= byte_in;
      drive_ff    <= drive_in;
      in_range_ff <= in_range_in;
      rsp_ff      <= rsp_in;
   end

endmodule
